// File: rtl/utf8d_pkg.sv
// shared types and constants for the utf-8 decoder with latin-1 fallback
package utf8d_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned CpW    = 21;
  localparam int unsigned MaxRes = 4;
  localparam int unsigned CntW   = $clog2(MaxRes + 1);

  // results caused by one input byte, in delivery order
  typedef struct packed {
    logic [MaxRes-1:0][CpW-1:0] cp;
    logic [CntW-1:0]            cnt;
    logic                       fin;
  } burst_t;

endpackage

// File: rtl/utf8d_core.sv
// decoder state and per-byte decode into a result burst
module utf8d_core
  import utf8d_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             take_i,
  input  logic [ByteW-1:0] data_byte_i,
  input  logic             final_byte_i,
  output burst_t           burst_o
);

  logic [ByteW-1:0] lead_q, lead_d;
  logic [ByteW-1:0] trail_q [2];
  logic [ByteW-1:0] trail_d [2];
  logic [1:0]       needed_q, needed_d;
  logic [1:0]       held_q, held_d;

  logic             is_trail;
  logic             lead_ok;
  logic [1:0]       fresh_n;
  logic             fresh_open;
  logic [1:0]       base;
  logic [4:0]       lead5;
  logic [CpW-1:0]   joined;
  logic [1:0]       held_p1;

  assign is_trail = data_byte_i[7:6] == 2'b10;
  assign lead_ok  = data_byte_i[7] && data_byte_i[6] &&
                    !(data_byte_i[5] && data_byte_i[4] && data_byte_i[3]);
  assign fresh_n  = !data_byte_i[5] ? 2'd1 : (!data_byte_i[4] ? 2'd2 : 2'd3);
  assign fresh_open = lead_ok && !final_byte_i;
  assign held_p1  = held_q + 2'd1;

  // lead payload bits by sequence length
  always_comb begin
    case (needed_q)
      2'd1:    lead5 = lead_q[4:0];
      2'd2:    lead5 = {1'b0, lead_q[3:0]};
      default: lead5 = {2'b00, lead_q[2:0]};
    endcase
  end

  always_comb begin
    case (held_q)
      2'd0:    joined = {10'd0, lead5, data_byte_i[5:0]};
      2'd1:    joined = {4'd0, lead5, trail_q[0][5:0], data_byte_i[5:0]};
      default: joined = {lead5[2:0], trail_q[0][5:0], trail_q[1][5:0], data_byte_i[5:0]};
    endcase
  end

  always_comb begin
    lead_d     = lead_q;
    trail_d[0] = trail_q[0];
    trail_d[1] = trail_q[1];
    needed_d   = needed_q;
    held_d     = held_q;
    base       = 2'd0;
    burst_o.cp[0] = {{(CpW-ByteW){1'b0}}, lead_q};
    burst_o.cp[1] = {{(CpW-ByteW){1'b0}}, trail_q[0]};
    burst_o.cp[2] = {{(CpW-ByteW){1'b0}}, trail_q[1]};
    burst_o.cp[3] = '0;
    burst_o.cnt   = '0;
    burst_o.fin   = final_byte_i;

    if (needed_q != 2'd0 && is_trail && held_p1 == needed_q) begin
      // sequence complete
      burst_o.cp[0] = joined;
      burst_o.cnt   = CntW'(1);
      needed_d      = 2'd0;
      held_d        = 2'd0;
    end else if (needed_q != 2'd0 && is_trail && !final_byte_i) begin
      trail_d[held_q[0]] = data_byte_i;
      held_d             = held_p1;
    end else begin
      if (needed_q != 2'd0) begin
        // broken or truncated: lead and held trails go out raw
        base     = held_p1;
        needed_d = 2'd0;
        held_d   = 2'd0;
      end
      if (fresh_open) begin
        burst_o.cnt = {1'b0, base};
        lead_d      = data_byte_i;
        needed_d    = fresh_n;
        held_d      = 2'd0;
      end else begin
        burst_o.cp[base] = {{(CpW-ByteW){1'b0}}, data_byte_i};
        burst_o.cnt      = {1'b0, base} + CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lead_q   <= '0;
      needed_q <= '0;
      held_q   <= '0;
    end else if (take_i) begin
      lead_q   <= lead_d;
      needed_q <= needed_d;
      held_q   <= held_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_i) begin
      trail_q[0] <= trail_d[0];
      trail_q[1] <= trail_d[1];
    end
  end

endmodule

// File: rtl/utf8d_burst.sv
// result register holding one burst, drained one result per transfer
module utf8d_burst
  import utf8d_pkg::*;
(
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           load_i,
  input  burst_t         burst_i,
  input  logic           out_stall_i,
  output logic           can_load_o,
  output logic           out_valid_o,
  output logic [CpW-1:0] code_point_o,
  output logic           last_of_run_o,
  output logic           string_done_o
);

  logic [MaxRes-1:0][CpW-1:0] cp_q, cp_d;
  logic [CntW-1:0]            cnt_q, cnt_d;
  logic                       fin_q, fin_d;
  logic                       out_fire;
  logic                       is_last;

  assign out_valid_o   = cnt_q != '0;
  assign out_fire      = out_valid_o && !out_stall_i;
  assign is_last       = cnt_q == CntW'(1);
  assign can_load_o    = !out_valid_o || (is_last && !out_stall_i);
  assign code_point_o  = cp_q[0];
  assign last_of_run_o = is_last;
  assign string_done_o = is_last && fin_q;

  always_comb begin
    cp_d  = cp_q;
    cnt_d = cnt_q;
    fin_d = fin_q;
    if (out_fire) begin
      for (int i = 0; i < MaxRes - 1; i++) begin
        cp_d[i] = cp_q[i+1];
      end
      cnt_d = cnt_q - CntW'(1);
    end
    if (load_i) begin
      cp_d  = burst_i.cp;
      cnt_d = burst_i.cnt;
      fin_d = burst_i.fin;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cp_q  <= cp_d;
    fin_q <= fin_d;
  end

endmodule

// File: rtl/utf8_decoder_latin1_fallback.sv
// top level: lenient utf-8 decoder with latin-1 fallback
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+----------------------------------------
//  in      | sink      | in_valid_i / in_stall_o | data_byte_i, final_byte_i
//  out     | source    | out_valid_o / out_stall_i | code_point_o, last_of_run_o, string_done_o
//
// a byte is latched in the input register, decoded once the result register can take its
// burst, and its results (zero to four) are loaded into the result register as one burst
// bytes that yield at most one result each are taken at one byte a cycle while the output
// does not stall; a fallback burst holds the input until only its last result is left
// the first result is offered once its burst is loaded and transfers when out_stall_i is low
// reset clears the input valid, the open sequence and the result count
// a stalled output stalls the input only once the input register is occupied
module utf8_decoder_latin1_fallback
  import utf8d_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [ByteW-1:0] data_byte_i,
  input  logic             final_byte_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [CpW-1:0]   code_point_o,
  output logic             last_of_run_o,
  output logic             string_done_o
);

  // input register
  logic             in_vld_q, in_vld_d;
  logic [ByteW-1:0] byte_q;
  logic             fin_q;

  logic   can_load;
  logic   take;
  logic   in_fire;
  burst_t burst;

  // the held byte is decoded once the result register can take its burst
  assign take       = in_vld_q && can_load;
  assign in_stall_o = in_vld_q && !take;
  assign in_fire    = in_valid_i && !in_stall_o;

  always_comb begin
    in_vld_d = in_vld_q;
    if (in_fire) begin
      in_vld_d = 1'b1;
    end else if (take) begin
      in_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= in_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      byte_q <= data_byte_i;
      fin_q  <= final_byte_i;
    end
  end

  // sequence tracking and decode
  utf8d_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .take_i       (take),
    .data_byte_i  (byte_q),
    .final_byte_i (fin_q),
    .burst_o      (burst)
  );

  // result register, one result per output transfer
  utf8d_burst u_burst (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_i        (take),
    .burst_i       (burst),
    .out_stall_i   (out_stall_i),
    .can_load_o    (can_load),
    .out_valid_o   (out_valid_o),
    .code_point_o  (code_point_o),
    .last_of_run_o (last_of_run_o),
    .string_done_o (string_done_o)
  );

endmodule
